@@ sv/kabf_pkg.sv @@
// kabf_pkg: shared types, constants and register indexes for the angle/bias kalman filter
// no dependencies
`default_nettype none
package kabf_pkg;
   localparam int WORD_WIDTH_DEF = 32;
   localparam int ANGLE_FRAC_DEF = 20;
   localparam int COV_FRAC_DEF = 28;
   localparam int DT_IN_FRAC = 28;
   localparam int CFG_WIDTH = 31;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ANGLE_NOISE = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BIAS_NOISE = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MEAS_NOISE = 2'd2;

   localparam logic [CFG_WIDTH-1:0] ANGLE_NOISE_RST = 31'd268435;
   localparam logic [CFG_WIDTH-1:0] BIAS_NOISE_RST = 31'd805306;
   localparam logic [CFG_WIDTH-1:0] MEAS_NOISE_RST = 31'd8053063;

   typedef struct packed {
      logic signed [31:0] measured_angle;
      logic signed [31:0] gyro_rate;
      logic [27:0] time_step;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] bias_estimate;
   } rsp_word_type;

   // control bits driven by the sequencer; start launches the divider
   typedef struct packed {
      logic start;
      logic is_div;
   } op_ctrl_type;
endpackage
`default_nettype wire

@@ sv/kabf_mul.sv @@
// kabf_mul: shared signed fixed-point multiplier, rounded and saturated; the raw product is registered
// depends on kabf_pkg
`default_nettype none
module kabf_mul #(
   parameter int WW = kabf_pkg::WORD_WIDTH_DEF,
   parameter int SH = kabf_pkg::COV_FRAC_DEF
) (
   input  wire logic                 clock,
   input  wire logic signed [WW-1:0] a,
   input  wire logic signed [WW-1:0] b,
   output logic signed [WW-1:0]      p
);
   import kabf_pkg::*;
   localparam int PW = 2 * WW;
   logic [WW-1:0] ma, mb;
   logic [PW-1:0] prod_ff, prod_in;
   logic neg_ff, neg_in;
   logic [PW:0] rnd;
   logic [PW:0] shd;
   logic [WW-1:0] maxp, maxn;
   always_comb begin
      ma = a[WW-1] ? WW'(-a) : WW'(a);
      mb = b[WW-1] ? WW'(-b) : WW'(b);
      prod_in = PW'(ma) * PW'(mb);
      neg_in = a[WW-1] ^ b[WW-1];
   end
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      neg_ff <= neg_in;
   end
   always_comb begin
      maxp = {1'b0, {(WW-1){1'b1}}};
      maxn = {1'b1, {(WW-1){1'b0}}};
      rnd = {1'b0, prod_ff} + ((PW+1)'(1) << (SH - 1));
      shd = rnd >> SH;
      if (neg_ff) begin
         p = (shd > (PW+1)'(maxn)) ? maxn : WW'(-shd[WW-1:0]);
      end else begin
         p = (shd > (PW+1)'(maxp)) ? maxp : shd[WW-1:0];
      end
   end
endmodule
`default_nettype wire

@@ sv/kabf_div.sv @@
// kabf_div: restoring divider, one quotient bit per cycle, (n << sh) / d saturated
// depends on kabf_pkg
`default_nettype none
module kabf_div #(
   parameter int WW = kabf_pkg::WORD_WIDTH_DEF,
   parameter int SH = kabf_pkg::COV_FRAC_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [WW-1:0] n,
   input  wire logic signed [WW-1:0] d,
   output logic                      done,
   output logic signed [WW-1:0]      q
);
   import kabf_pkg::*;
   localparam int NB = WW + SH;
   localparam int CW = $clog2(NB + 1);
   logic [NB-1:0] num_ff, num_in;
   logic [WW:0] rem_ff, rem_in, trial;
   logic [WW:0] quo_ff, quo_in;
   logic ovf_ff, ovf_in, neg_ff, neg_in, zero_ff, zero_in;
   logic [WW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [WW-1:0] un, ud, maxp, maxn;
   always_comb begin
      un = n[WW-1] ? WW'(-n) : WW'(n);
      ud = d[WW-1] ? WW'(-d) : WW'(d);
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; ovf_in = ovf_ff;
      neg_in = neg_ff; zero_in = zero_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done = 1'b0;
      trial = {rem_ff[WW-1:0], num_ff[NB-1]};
      if (start) begin
         num_in = {un, {SH{1'b0}}};
         den_in = ud; rem_in = '0; quo_in = '0; ovf_in = 1'b0;
         neg_in = n[WW-1] ^ d[WW-1]; zero_in = (ud == '0);
         cnt_in = CW'(NB); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0; done = 1'b1;
         end else begin
            num_in = num_ff << 1;
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               quo_in = {quo_ff[WW-1:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[WW-1:0], 1'b0};
            end
            if (quo_ff[WW] || quo_ff[WW-1]) ovf_in = 1'b1;
            cnt_in = cnt_ff - 1'b1;
         end
      end
      maxp = {1'b0, {(WW-1){1'b1}}};
      maxn = {1'b1, {(WW-1){1'b0}}};
      if (zero_ff) q = '0;
      else if (neg_ff) q = (ovf_ff || quo_ff > {1'b0, maxn}) ? maxn : WW'(-quo_ff[WW-1:0]);
      else q = (ovf_ff || quo_ff > {1'b0, maxp}) ? maxp : quo_ff[WW-1:0];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; ovf_ff <= ovf_in;
      neg_ff <= neg_in; zero_ff <= zero_in; den_ff <= den_in; cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

@@ sv/kalman_angle_bias_filter.sv @@
// Two-state angle / gyro-bias kalman filter, fixed point. After a sample is accepted, a
// sequencer walks the equations through one shared multiplier, one product per step, and
// a bit-serial divider that runs twice per sample for the two gains. The result waits in
// an output register, so ready is low only while a sample is in flight; a new sample is
// accepted only once the previous one is through, and the last step holds while a result
// is unread. No clearing pass after reset.
// depends on kabf_pkg, kabf_mul, kabf_div
`default_nettype none
module kalman_angle_bias_filter #(
   parameter int WORD_WIDTH = kabf_pkg::WORD_WIDTH_DEF,
   parameter int ANGLE_FRAC_BITS = kabf_pkg::ANGLE_FRAC_DEF,
   parameter int COV_FRAC_BITS = kabf_pkg::COV_FRAC_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire kabf_pkg::req_word_type              req_word,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output kabf_pkg::rsp_word_type                   rsp_word,
   input  wire logic                                csr_write,
   input  wire logic [kabf_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [kabf_pkg::CFG_WIDTH-1:0]      csr_data
);
   import kabf_pkg::*;
   localparam int WW = WORD_WIDTH;
   localparam int SHD = COV_FRAC_BITS - DT_IN_FRAC;
   localparam logic signed [WW-1:0] WMAX = {1'b0, {(WW-1){1'b1}}};
   localparam logic signed [WW-1:0] WMIN = {1'b1, {(WW-1){1'b0}}};

   localparam logic [4:0] S_IDLE = 5'd0, S_M1 = 5'd1, S_M2 = 5'd2, S_M3 = 5'd3,
      S_M4 = 5'd4, S_M5 = 5'd5, S_D0 = 5'd6, S_D0W = 5'd7, S_D1 = 5'd8, S_D1W = 5'd9,
      S_M6 = 5'd10, S_M7 = 5'd11, S_M8 = 5'd12, S_M9 = 5'd13, S_M10 = 5'd14,
      S_M11 = 5'd15, S_OUT = 5'd16;

   logic [4:0] st_ff, st_in;
   logic [1:0] ph_ff, ph_in;
   logic signed [WW-1:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [WW-1:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [WW-1:0] dt_ff, dt_in, rate_ff, rate_in, meas_ff, meas_in;
   logic signed [WW-1:0] y_ff, y_in, k0_ff, k0_in, k1_ff, k1_in, t_ff, t_in;
   logic signed [WW-1:0] pa_ff, pa_in, pb_ff, pb_in, s_ff, s_in;
   logic [CFG_WIDTH-1:0] qa_ff, qb_ff, rm_ff;
   logic signed [WW-1:0] ma, mb, mp, dn, dd, dq;
   op_ctrl_type dctl;
   logic ddone;
   logic rv_ff, rv_in;
   rsp_word_type rw_ff, rw_in;

   function automatic logic signed [WW-1:0] sadd(input logic signed [WW-1:0] x,
                                                  input logic signed [WW-1:0] y2,
                                                  input logic sub);
      logic signed [WW:0] r;
      begin
         r = sub ? ((WW+1)'(x) - (WW+1)'(y2)) : ((WW+1)'(x) + (WW+1)'(y2));
         if (r > (WW+1)'(WMAX)) sadd = WMAX;
         else if (r < (WW+1)'(WMIN)) sadd = WMIN;
         else sadd = r[WW-1:0];
      end
   endfunction

   // m - c1 - c2 + nz at full width, saturated once
   function automatic logic signed [WW-1:0] tsum(input logic signed [WW-1:0] m,
                                                  input logic signed [WW-1:0] c1,
                                                  input logic signed [WW-1:0] c2,
                                                  input logic signed [WW-1:0] nz);
      logic signed [WW+2:0] r;
      begin
         r = (WW+3)'(m) - (WW+3)'(c1) - (WW+3)'(c2) + (WW+3)'(nz);
         if (r > (WW+3)'(WMAX)) tsum = WMAX;
         else if (r < (WW+3)'(WMIN)) tsum = WMIN;
         else tsum = r[WW-1:0];
      end
   endfunction

   function automatic logic signed [WW-1:0] from32(input logic [31:0] v);
      logic signed [63:0] e;
      begin
         e = 64'(signed'(v));
         if (e > 64'(WMAX)) from32 = WMAX;
         else if (e < 64'(WMIN)) from32 = WMIN;
         else from32 = WW'(e);
      end
   endfunction

   function automatic logic [31:0] to32(input logic signed [WW-1:0] v);
      logic signed [63:0] e;
      begin
         e = 64'(v);
         if (e > 64'sh7FFFFFFF) to32 = 32'h7FFFFFFF;
         else if (e < -64'sh80000000) to32 = 32'h80000000;
         else to32 = e[31:0];
      end
   endfunction

   function automatic logic signed [WW-1:0] cfgw(input logic [CFG_WIDTH-1:0] v);
      logic [63:0] e;
      begin
         e = 64'(v);
         cfgw = (e > 64'(WMAX)) ? WMAX : WW'(e);
      end
   endfunction

   function automatic logic signed [WW-1:0] dtconv(input logic [27:0] v);
      logic [127:0] e;
      begin
         e = 128'(v);
         if (SHD >= 0) e = e << SHD;
         else e = e >> (-SHD);
         dtconv = (e > 128'(WMAX)) ? WMAX : WW'(e);
      end
   endfunction

   kabf_mul #(.WW(WW), .SH(COV_FRAC_BITS)) u_mul (
      .clock(clock), .a(ma), .b(mb), .p(mp));

   kabf_div #(.WW(WW), .SH(COV_FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(dctl.start), .n(dn), .d(dd),
      .done(ddone), .q(dq));

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= ANGLE_NOISE_RST; qb_ff <= BIAS_NOISE_RST; rm_ff <= MEAS_NOISE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ANGLE_NOISE: qa_ff <= csr_data;
            CSR_BIAS_NOISE: qb_ff <= csr_data;
            CSR_MEAS_NOISE: rm_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_word = rw_ff;

   always_comb begin
      st_in = st_ff; ph_in = ph_ff;
      ang_in = ang_ff; bias_in = bias_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      dt_in = dt_ff; rate_in = rate_ff; meas_in = meas_ff; y_in = y_ff;
      k0_in = k0_ff; k1_in = k1_ff; t_in = t_ff; pa_in = pa_ff; pb_in = pb_ff;
      s_in = s_ff;
      rv_in = rv_ff; rw_in = rw_ff;
      ma = dt_ff; mb = rate_ff;
      dctl = '0; dn = p00_ff; dd = s_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      ph_in = (ph_ff == 2'd2) ? 2'd0 : ph_ff + 2'd1;
      unique case (st_ff)
         S_IDLE: begin
            ph_in = 2'd0;
            if (req_valid && req_ready) begin
               meas_in = from32(req_word.measured_angle);
               dt_in = dtconv(req_word.time_step);
               rate_in = sadd(from32(req_word.gyro_rate), bias_ff, 1'b1);
               st_in = S_M1;
            end
         end
         S_M1: begin
            ma = dt_ff; mb = rate_ff;
            if (ph_ff == 2'd2) begin
               ang_in = sadd(ang_ff, mp, 1'b0); st_in = S_M2;
            end
         end
         S_M2: begin
            ma = dt_ff; mb = p11_ff;
            if (ph_ff == 2'd2) begin
               t_in = tsum(mp, p01_ff, p10_ff, cfgw(qa_ff));
               p01_in = sadd(p01_ff, mp, 1'b1);
               p10_in = sadd(p10_ff, mp, 1'b1);
               st_in = S_M3;
            end
         end
         S_M3: begin
            ma = dt_ff; mb = t_ff;
            if (ph_ff == 2'd2) begin
               p00_in = sadd(p00_ff, mp, 1'b0); st_in = S_M4;
            end
         end
         S_M4: begin
            ma = cfgw(qb_ff); mb = dt_ff;
            if (ph_ff == 2'd2) begin
               p11_in = sadd(p11_ff, mp, 1'b0); st_in = S_M5;
            end
         end
         S_M5: begin
            y_in = sadd(meas_ff, ang_ff, 1'b1);
            s_in = sadd(p00_ff, cfgw(rm_ff), 1'b0);
            pa_in = p00_ff; pb_in = p01_ff;
            st_in = S_D0;
         end
         S_D0: begin
            dctl.start = 1'b1; dn = p00_ff; st_in = S_D0W;
         end
         S_D0W: begin
            if (ddone) begin
               k0_in = dq; st_in = S_D1;
            end
         end
         S_D1: begin
            dctl.start = 1'b1; dn = p10_ff; st_in = S_D1W;
         end
         S_D1W: begin
            ph_in = 2'd0;
            if (ddone) begin
               k1_in = dq; st_in = S_M6;
            end
         end
         S_M6: begin
            ma = k0_ff; mb = y_ff;
            if (ph_ff == 2'd2) begin
               ang_in = sadd(ang_ff, mp, 1'b0); st_in = S_M7;
            end
         end
         S_M7: begin
            ma = k1_ff; mb = y_ff;
            if (ph_ff == 2'd2) begin
               bias_in = sadd(bias_ff, mp, 1'b0); st_in = S_M8;
            end
         end
         S_M8: begin
            ma = k0_ff; mb = pa_ff;
            if (ph_ff == 2'd2) begin
               p00_in = sadd(p00_ff, mp, 1'b1); st_in = S_M9;
            end
         end
         S_M9: begin
            ma = k0_ff; mb = pb_ff;
            if (ph_ff == 2'd2) begin
               p01_in = sadd(p01_ff, mp, 1'b1); st_in = S_M10;
            end
         end
         S_M10: begin
            ma = k1_ff; mb = pa_ff;
            if (ph_ff == 2'd2) begin
               p10_in = sadd(p10_ff, mp, 1'b1); st_in = S_M11;
            end
         end
         S_M11: begin
            ma = k1_ff; mb = pb_ff;
            if (ph_ff == 2'd2) begin
               p11_in = sadd(p11_ff, mp, 1'b1); st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_ready) begin
               rw_in.filtered_angle = to32(ang_ff);
               rw_in.bias_estimate = to32(bias_ff);
               rv_in = 1'b1;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ph_ff <= 2'd0; rv_ff <= 1'b0;
         ang_ff <= '0; bias_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; rv_ff <= rv_in;
         ang_ff <= ang_in; bias_ff <= bias_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
      end
      dt_ff <= dt_in; rate_ff <= rate_in; meas_ff <= meas_in; y_ff <= y_in;
      k0_ff <= k0_in; k1_ff <= k1_in; t_ff <= t_in; pa_ff <= pa_in; pb_ff <= pb_in;
      s_ff <= s_in; rw_ff <= rw_in;
   end

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !req_ready) else $error("accept while busy");
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_OUT) |=> rsp_valid) else $error("result lost");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (st_ff == S_M1)) else $error("sequencer did not start");
`endif
endmodule
`default_nettype wire
